### rtl/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file in rtl/ but u8d_byte_if.sv imports this package.
package u8d_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEAD  = 2'd1,
        ST_BAD_CONT  = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    localparam int unsigned CP_W      = 31;
    localparam int unsigned PENDING_W = 3;

    // Payload bit masks for each lead byte form and for continuation bytes.
    localparam logic [7:0] MASK_LEAD2 = 8'h1F;
    localparam logic [7:0] MASK_LEAD3 = 8'h0F;
    localparam logic [7:0] MASK_LEAD4 = 8'h07;
    localparam logic [7:0] MASK_LEAD5 = 8'h03;
    localparam logic [7:0] MASK_LEAD6 = 8'h01;
    localparam logic [7:0] MASK_CONT  = 8'h3F;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [PENDING_W-1:0] pending;
        logic [CP_W-1:0]      partial;
        logic                 discarding;
    } state_t;

    // One result request.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            at_end;
    } result_t;

endpackage

### rtl/u8d_byte_if.sv
// Byte channel into the decoder: valid/ready handshake with the byte payload.
// Depends on nothing but its own signals.
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       string_end;

    modport source (output valid, output byte_in, output string_end, input ready);
    modport sink   (input valid, input byte_in, input string_end, output ready);
endinterface

### rtl/u8d_result_if.sv
// Result channel out of the decoder: valid/ready handshake with the code point.
// Depends on u8d_pkg for the status type.
interface u8d_result_if;
    import u8d_pkg::*;

    logic            valid;
    logic            ready;
    logic [CP_W-1:0] code_point;
    status_t         status;
    logic            at_end;

    modport source (output valid, output code_point, output status, output at_end,
                    input ready);
    modport sink   (input valid, input code_point, input status, input at_end,
                    output ready);
endinterface

### rtl/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decode step, result register.
// Depends on u8d_pkg, u8d_byte_if, u8d_result_if and u8d_step.
//
// Usage:
//   Bytes of a string arrive on the stream channel, one request per byte, with
//   string_end set on the last byte. Decoded code points and error results leave
//   on the decoded channel, at most one request per byte. An error result has
//   code point zero; after one, bytes are dropped up to the end of the string.
//   Throughput: one byte per cycle while the receiver takes results. A byte is
//   captured in the input register and decoded combinationally against the
//   state registers; its result, if any, is written into the result register
//   once that register is free, and the result register offers it on the
//   decoded channel. The decode step is one shift-and-OR plus a three-bit
//   counter update.
//   Reset clears the input register, the decoder state and the result register.
//   When the receiver stalls, the result register holds its request, the byte in
//   the input register waits, and stream.ready falls once both are occupied;
//   nothing is lost or repeated.
module utf8_stream_decoder (
    input logic          clk,
    input logic          rst_n,
    u8d_byte_if.sink     stream,
    u8d_result_if.source decoded
);
    import u8d_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;

    state_t     state_reg;
    state_t     state_next;
    logic       emit;
    result_t    result;

    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_reg;

    logic       out_free;
    logic       advance;

    // Handshake: the held byte moves on whenever the result register can take it.
    assign out_free     = !out_valid_reg || decoded.ready;
    assign advance      = s1_valid_reg && out_free;
    assign stream.ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            s1_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            s1_byte_reg <= stream.byte_in;
            s1_end_reg  <= stream.string_end;
        end
    end

    // Decode step on the held byte.
    u8d_step u_step (
        .state      (state_reg),
        .byte_in    (s1_byte_reg),
        .string_end (s1_end_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_comb
    begin
        out_valid_next = out_valid_reg && !decoded.ready;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    assign decoded.valid      = out_valid_reg;
    assign decoded.code_point = out_reg.code_point;
    assign decoded.status     = out_reg.status;
    assign decoded.at_end     = out_reg.at_end;

    // At most five continuation bytes are ever outstanding.
    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pending <= 3'd5)
        else $error("pending count out of range");

    // While dropping bytes no sequence is open.
    a_discard_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.discarding |-> (state_reg.pending == '0 && state_reg.partial == '0))
        else $error("open sequence while discarding");

    // The final byte of a string leaves the decoder fully cleared.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_end_reg) |=> (state_reg == '0))
        else $error("state not cleared at end of string");

    // Error results carry a zero code point.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK) |-> (out_reg.code_point == '0))
        else $error("error result with nonzero code point");

endmodule

### rtl/u8d_step.sv
// Combinational decode of one byte against the current decoder state.
// Depends on u8d_pkg for the state and result types.
module u8d_step (
    input  u8d_pkg::state_t  state,
    input  logic [7:0]       byte_in,
    input  logic             string_end,
    output u8d_pkg::state_t  state_next,
    output logic             emit,
    output u8d_pkg::result_t result
);
    import u8d_pkg::*;

    logic [PENDING_W-1:0] lead_more;
    logic [CP_W-1:0]      lead_val;
    logic                 lead_bad;
    logic [CP_W-1:0]      cont_val;
    logic [PENDING_W-1:0] cont_pending;
    state_t               zero_state;

    assign zero_state = '0;

    // Classify a lead byte: continuation count and kept payload bits.
    always_comb
    begin
        lead_more = '0;
        lead_val  = '0;
        lead_bad  = 1'b0;
        if (byte_in[7] == 1'b0)
        begin
            lead_val = {{(CP_W-8){1'b0}}, byte_in};
        end
        else if (byte_in[7:5] == 3'b110)
        begin
            lead_more = 3'd1;
            lead_val  = {{(CP_W-8){1'b0}}, byte_in & MASK_LEAD2};
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            lead_more = 3'd2;
            lead_val  = {{(CP_W-8){1'b0}}, byte_in & MASK_LEAD3};
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            lead_more = 3'd3;
            lead_val  = {{(CP_W-8){1'b0}}, byte_in & MASK_LEAD4};
        end
        else if (byte_in[7:2] == 6'b111110)
        begin
            lead_more = 3'd4;
            lead_val  = {{(CP_W-8){1'b0}}, byte_in & MASK_LEAD5};
        end
        else if (byte_in[7:1] == 7'b1111110)
        begin
            lead_more = 3'd5;
            lead_val  = {{(CP_W-8){1'b0}}, byte_in & MASK_LEAD6};
        end
        else
        begin
            lead_bad = 1'b1;
        end
    end

    // A continuation byte shifts in six more value bits.
    assign cont_val     = {state.partial[CP_W-7:0], byte_in[5:0] & MASK_CONT[5:0]};
    assign cont_pending = state.pending - 3'd1;

    // State update and result selection.
    always_comb
    begin
        state_next        = state;
        emit              = 1'b0;
        result.code_point = '0;
        result.status     = ST_OK;
        result.at_end     = string_end;

        if (state.discarding)
        begin
            if (string_end)
            begin
                state_next = zero_state;
            end
        end
        else if (state.pending == '0)
        begin
            if (lead_bad)
            begin
                emit                  = 1'b1;
                result.status         = ST_BAD_LEAD;
                state_next            = zero_state;
                state_next.discarding = !string_end;
            end
            else if (lead_more == '0)
            begin
                emit              = 1'b1;
                result.code_point = lead_val;
                if (string_end)
                begin
                    state_next = zero_state;
                end
            end
            else if (string_end)
            begin
                emit          = 1'b1;
                result.status = ST_TRUNCATED;
                state_next    = zero_state;
            end
            else
            begin
                state_next.pending = lead_more;
                state_next.partial = lead_val;
            end
        end
        else if (byte_in[7:6] != 2'b10)
        begin
            emit                  = 1'b1;
            result.status         = ST_BAD_CONT;
            state_next            = zero_state;
            state_next.discarding = !string_end;
        end
        else if (cont_pending == '0)
        begin
            emit              = 1'b1;
            result.code_point = cont_val;
            state_next        = zero_state;
        end
        else if (string_end)
        begin
            emit          = 1'b1;
            result.status = ST_TRUNCATED;
            state_next    = zero_state;
        end
        else
        begin
            state_next.pending = cont_pending;
            state_next.partial = cont_val;
        end
    end

endmodule
